FILE: rtl/core/spi_transfer_batch_controller_macros.svh
// Assertion macros shared by the checker of the SPI transfer batch controller.
`ifndef SPI_TRANSFER_BATCH_CONTROLLER_MACROS_SVH
`define SPI_TRANSFER_BATCH_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk and silenced during reset.
`define STBC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and silenced during reset.
`define STBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/stbc_pkg.sv
// Shared types, codes and field layout of the SPI transfer batch controller.
package stbc_pkg;

	localparam int BATCH_LIMIT_DEF = 8;

	// Configuration register indexes
	localparam logic [7:0] REG_CAP_REQ   = 8'd0;
	localparam logic [7:0] REG_SETTLE_EN = 8'd1;

	// Pass outcome codes
	typedef enum logic [2:0] {
		OUT_DONE        = 3'd0,
		OUT_IDLE        = 3'd1,
		OUT_NOT_READY   = 3'd2,
		OUT_SETTLE_MISS = 3'd3,
		OUT_XFER_ERR    = 3'd4,
		OUT_CAP         = 3'd5
	} outcome_t;

	// Input tdata layout
	localparam int IN_DATA_W   = 8;
	localparam int IN_TX_BIT   = 0;
	localparam int IN_DR_BIT   = 1;
	localparam int IN_HS_BIT   = 2;
	localparam int IN_SET_BIT  = 3;
	localparam int IN_XOK_BIT  = 4;

	// Output tdata layout
	localparam int OUT_DATA_W    = 200;
	localparam int OUTCOME_LSB   = 0;
	localparam int USED_BIT      = 3;
	localparam int BCOUNT_LSB    = 4;
	localparam int CALLS_LSB     = 8;
	localparam int XFERS_LSB     = 40;
	localparam int HITS_LSB      = 72;
	localparam int MISSES_LSB    = 104;
	localparam int ERRORS_LSB    = 136;
	localparam int LEN_HITS_LSB  = 168;

	// Histogram unit control
	typedef struct packed {
		logic advance;  // the pass in stage 1 moves on this cycle
		logic bump;     // the pass in stage 1 ends a batch
	} hist_ctl_t;

endpackage

FILE: rtl/core/spi_transfer_batch_controller.sv
// SPI transfer batch controller: per-pass continue/stop decision with statistics.
// Result passes stage 1, then the output register; one pass per cycle unless stalled.
// Histogram kept in a synchronous RAM with forwarding; its port sets the stage split.
// Reset clears all counters, the batch state and the histogram valid bits at once.
module spi_transfer_batch_controller import stbc_pkg::*; #(
	parameter int BATCH_LIMIT = BATCH_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pass observations
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // frame queued, slave ready, handshake,
	                                          // settle ok, transfer ok, zero pad
	// pass results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // outcome, settle_used, batch_count,
	                                          // total_calls, total_transfers,
	                                          // settle_hit_count, settle_miss_count,
	                                          // error_count, length_hits
	output logic                  m_tlast,   // batch_end
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_index,
	input  logic [7:0]            cfg_data
);

	localparam int DW = $clog2(BATCH_LIMIT + 1);
	localparam logic [7:0] LIMIT8 = 8'(BATCH_LIMIT);

	// Registers
	logic [7:0] cap_req_q;
	logic       settle_en_q;

	// Batch state and statistics
	logic          in_batch_q;
	logic [DW-1:0] done_q;
	logic [31:0]   calls_q, xfers_q, hits_q, misses_q, errors_q;

	// Decision for the pass on the input
	logic          accept;
	logic          tx, dr, hs, settle, xok;
	logic [7:0]    cap;
	logic [DW-1:0] cur_done, new_done;
	logic [31:0]   calls_nx;
	outcome_t      outcome;
	logic          used, ends, go;
	logic          hit_inc, miss_inc, err_inc;

	// Stage 1
	logic          valid_s1;
	outcome_t      outcome_s1;
	logic          used_s1, end_s1;
	logic [3:0]    bcount_s1;
	logic [DW-1:0] bin_s1;
	logic [31:0]   calls_s1, xfers_s1, hits_s1, misses_s1, errors_s1;
	logic          adv_s1;

	// Output register
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  m_last_q;

	hist_ctl_t     hctl;
	logic [DW-1:0] rd_addr;
	logic [31:0]   hist_count;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_req_q   <= 8'd0;
			settle_en_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CAP_REQ:   cap_req_q   <= cfg_data;
				REG_SETTLE_EN: settle_en_q <= cfg_data[0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// Stage 1 moves whenever the output register is free or being drained
	assign adv_s1   = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	assign tx     = s_tdata[IN_TX_BIT];
	assign dr     = s_tdata[IN_DR_BIT];
	assign hs     = s_tdata[IN_HS_BIT];
	assign settle = s_tdata[IN_SET_BIT];
	assign xok    = s_tdata[IN_XOK_BIT];

	// Zero selects the build limit; anything above it is clamped
	assign cap = (cap_req_q == 8'd0 || cap_req_q > LIMIT8) ? LIMIT8 : cap_req_q;

	// A pass outside a batch opens a new call with an empty count
	assign cur_done = in_batch_q ? done_q : '0;
	assign calls_nx = in_batch_q ? calls_q : calls_q + 32'd1;

	always_comb begin
		outcome  = OUT_DONE;
		used     = 1'b0;
		ends     = 1'b0;
		go       = 1'b1;
		hit_inc  = 1'b0;
		miss_inc = 1'b0;
		err_inc  = 1'b0;
		new_done = cur_done;
		if (8'(cur_done) >= cap) begin
			// cap lowered to or under the running count: stop without looking at the inputs
			outcome = OUT_CAP;
			ends    = 1'b1;
		end else if (!tx && !dr) begin
			outcome = OUT_IDLE;
			ends    = 1'b1;
		end else begin
			if (!hs) begin
				if (cur_done == '0 || !settle_en_q) begin
					outcome = OUT_NOT_READY;
					ends    = 1'b1;
					go      = 1'b0;
				end else if (!settle) begin
					outcome  = OUT_SETTLE_MISS;
					ends     = 1'b1;
					go       = 1'b0;
					miss_inc = 1'b1;
				end else begin
					hit_inc = 1'b1;
					used    = 1'b1;
				end
			end
			if (go) begin
				if (!xok) begin
					outcome = OUT_XFER_ERR;
					ends    = 1'b1;
					err_inc = 1'b1;
				end else begin
					new_done = cur_done + DW'(1);
					if (8'(new_done) >= cap) begin
						outcome = OUT_CAP;
						ends    = 1'b1;
					end
				end
			end
		end
	end

	// Batch state and counters change only on an accepted pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_batch_q <= 1'b0;
			done_q     <= '0;
			calls_q    <= '0;
			xfers_q    <= '0;
			hits_q     <= '0;
			misses_q   <= '0;
			errors_q   <= '0;
		end else if (accept) begin
			in_batch_q <= !ends;
			done_q     <= new_done;
			calls_q    <= calls_nx;
			if (ends) begin
				xfers_q <= xfers_q + 32'(new_done);
			end
			if (hit_inc) begin
				hits_q <= hits_q + 32'd1;
			end
			if (miss_inc) begin
				misses_q <= misses_q + 32'd1;
			end
			if (err_inc) begin
				errors_q <= errors_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Snapshot the pass; statistics shown are those after this pass
	always_ff @(posedge clk) begin
		if (accept) begin
			outcome_s1 <= outcome;
			used_s1    <= used;
			end_s1     <= ends;
			bcount_s1  <= 4'(new_done);
			bin_s1     <= new_done;
			calls_s1   <= calls_nx;
			xfers_s1   <= ends ? xfers_q + 32'(new_done) : xfers_q;
			hits_s1    <= hit_inc ? hits_q + 32'd1 : hits_q;
			misses_s1  <= miss_inc ? misses_q + 32'd1 : misses_q;
			errors_s1  <= err_inc ? errors_q + 32'd1 : errors_q;
		end
	end

	// Read the bin of a new pass; re-read the held bin while stage 1 waits
	assign rd_addr      = accept ? new_done : bin_s1;
	assign hctl.advance = valid_s1 && adv_s1;
	assign hctl.bump    = end_s1;

	stbc_hist #(
		.BATCH_LIMIT(BATCH_LIMIT)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (hctl),
		.rd_addr (rd_addr),
		.cur_addr(bin_s1),
		.count   (hist_count)
	);

	// Output register parts the result from the next pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			m_last_q <= end_s1;
			m_data_q <= {end_s1 ? hist_count : 32'd0, errors_s1, misses_s1, hits_s1,
				xfers_s1, calls_s1, bcount_s1, used_s1, outcome_s1};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

FILE: rtl/core/stbc_hist.sv
// Batch-length histogram: synchronous RAM with read-modify-write and forwarding.
module stbc_hist import stbc_pkg::*; #(
	parameter int BATCH_LIMIT = BATCH_LIMIT_DEF,
	localparam int DEPTH = BATCH_LIMIT + 1,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hist_ctl_t     ctl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] cur_addr,
	output logic [31:0]   count
);

	logic [31:0]      mem [DEPTH];
	logic [31:0]      rdata_q;
	logic [DEPTH-1:0] valid_q;
	logic             fwd_valid_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [31:0]      fwd_data_q;
	logic [31:0]      base;
	logic             wr_en;

	assign wr_en = ctl.advance && ctl.bump;

	// The last write beats the RAM read issued at the same edge
	always_comb begin
		if (fwd_valid_q && fwd_addr_q == cur_addr) begin
			base = fwd_data_q;
		end else if (valid_q[cur_addr]) begin
			base = rdata_q;
		end else begin
			base = '0;
		end
	end

	assign count = base + 32'd1;

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (wr_en) begin
			mem[cur_addr] <= count;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= cur_addr;
		fwd_data_q <= count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
			if (wr_en) begin
				valid_q[cur_addr] <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/stbc_checker.sv
// Port-level assertions of the SPI transfer batch controller and their binding.
`include "spi_transfer_batch_controller_macros.svh"

module stbc_checker import stbc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	logic [2:0]  res_outcome;
	logic        res_used;
	logic [31:0] res_len_hits;

	assign res_outcome  = m_tdata[OUTCOME_LSB +: 3];
	assign res_used     = m_tdata[USED_BIT];
	assign res_len_hits = m_tdata[LEN_HITS_LSB +: 32];

	// hold a stalled result
	`STBC_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

	// only a continuing pass leaves the batch open
	`STBC_ASSERT_SAME(a_end_outcome, m_tvalid, m_tlast == (res_outcome != OUT_DONE), "batch end disagrees with outcome")

	// a settle hit goes on to a transfer
	`STBC_ASSERT_SAME(a_settle_path, m_tvalid && res_used, res_outcome == OUT_DONE || res_outcome == OUT_XFER_ERR || res_outcome == OUT_CAP, "settle hit with a stopping outcome")

	// histogram count shows only at a batch end
	`STBC_ASSERT_SAME(a_hist_quiet, m_tvalid && !m_tlast, res_len_hits == 32'd0, "histogram count outside batch end")

endmodule

bind spi_transfer_batch_controller stbc_checker u_stbc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
